[design/spe_pkg.sv]
// package for the simple processor execute block
// holds storage sizes, opcode and request codes, port field widths and controller/datapath structs
// no dependencies
`timescale 1ns / 1ps

package spe_pkg;

	// default storage sizes (memory depth must be a power of two)
	localparam int SPE_WORD_BITS = 16;
	localparam int SPE_MEM_WORDS = 256;

	// fixed field widths of the ports
	localparam int PORT_ADDR_BITS = 8;
	localparam int PORT_DATA_BITS = 16;
	localparam int REG_IDX_BITS   = 3;

	// request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	// opcodes, instruction bits 15..13
	localparam logic [2:0] OP_MV   = 3'd0;
	localparam logic [2:0] OP_MVI  = 3'd1;
	localparam logic [2:0] OP_ADD  = 3'd2;
	localparam logic [2:0] OP_SUB  = 3'd3;
	localparam logic [2:0] OP_LD   = 3'd4;
	localparam logic [2:0] OP_ST   = 3'd5;
	localparam logic [2:0] OP_MVNZ = 3'd6;
	localparam logic [2:0] OP_BAD  = 3'd7;

	// register 7 is the program counter
	localparam logic [REG_IDX_BITS-1:0] REG_PC = 3'd7;

	// controller to datapath commands
	typedef struct packed {
		logic load_wr;       // write the load item's word into memory
		logic fetch;         // read instruction word at pc
		logic decode;        // latch fields, read registers, advance pc
		logic ld_read;       // read memory at ry for a load instruction
		logic finish_load;   // capture result of a load item
		logic finish_instr;  // retire instruction and capture result
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [2:0] op;      // opcode of the instruction in execute
	} ctrl_sts_t;

endpackage

[design/spe_ctrl.sv]
// controller state machine of the simple processor execute block
// sequences load items and fetch, decode, execute and result handoff; depends on spe_pkg
`timescale 1ns / 1ps

module spe_ctrl import spe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      req_type,
	output logic      out_valid,
	input  logic      out_stall,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_EXEC   = 3'd2;
	localparam logic [2:0] S_LDWAIT = 3'd3;
	localparam logic [2:0] S_LDONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	// input taken only while idle
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == REQ_LOAD) begin
						cmd.load_wr = 1'b1;
						state_nxt   = S_LDONE;
					end else begin
						cmd.fetch = 1'b1;
						state_nxt = S_DECODE;
					end
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				state_nxt  = S_EXEC;
			end
			S_EXEC: begin
				if (sts.op == OP_LD) begin
					cmd.ld_read = 1'b1;
					state_nxt   = S_LDWAIT;
				end else if (out_free) begin
					cmd.finish_instr = 1'b1;
					state_nxt        = S_IDLE;
				end
			end
			S_LDWAIT: begin
				if (out_free) begin
					cmd.finish_instr = 1'b1;
					state_nxt        = S_IDLE;
				end
			end
			S_LDONE: begin
				if (out_free) begin
					cmd.finish_load = 1'b1;
					state_nxt       = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish_load || cmd.finish_instr) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[design/spe_datapath.sv]
// datapath of the simple processor execute block
// word memory, register file, pc, g, alu and result register; depends on spe_pkg
`timescale 1ns / 1ps

module spe_datapath import spe_pkg::*; #(
	parameter int WORD_BITS = SPE_WORD_BITS,
	parameter int MEM_WORDS = SPE_MEM_WORDS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctrl_cmd_t                 cmd,
	output ctrl_sts_t                 sts,
	input  logic [PORT_ADDR_BITS-1:0] load_addr,
	input  logic [PORT_DATA_BITS-1:0] load_data,
	output logic [PORT_DATA_BITS-1:0] pc_after,
	output logic                      reg_written,
	output logic [REG_IDX_BITS-1:0]   reg_index,
	output logic [PORT_DATA_BITS-1:0] reg_value,
	output logic                      mem_written,
	output logic [PORT_ADDR_BITS-1:0] store_addr,
	output logic [PORT_DATA_BITS-1:0] store_data,
	output logic [PORT_DATA_BITS-1:0] g_value,
	output logic                      bad_opcode
);

	localparam int ADDR_BITS = $clog2(MEM_WORDS);
	localparam int NUM_REGS  = 2 ** REG_IDX_BITS;

	// storage
	logic [WORD_BITS-1:0] mem [MEM_WORDS];
	logic [WORD_BITS-1:0] rd_q;
	logic [WORD_BITS-1:0] rf_mem [NUM_REGS];
	logic [NUM_REGS-1:0]  rf_vld_q;
	logic [WORD_BITS-1:0] pc_q;
	logic [WORD_BITS-1:0] g_q;

	// decoded instruction and operand reads
	logic [2:0]              op_q;
	logic [REG_IDX_BITS-1:0] rx_q;
	logic [REG_IDX_BITS-1:0] ry_q;
	logic [WORD_BITS-1:0]    rx_raw_q;
	logic [WORD_BITS-1:0]    ry_raw_q;

	// result register
	logic [PORT_DATA_BITS-1:0] pc_after_q;
	logic                      reg_written_q;
	logic [REG_IDX_BITS-1:0]   reg_index_q;
	logic [PORT_DATA_BITS-1:0] reg_value_q;
	logic                      mem_written_q;
	logic [PORT_ADDR_BITS-1:0] store_addr_q;
	logic [PORT_DATA_BITS-1:0] store_data_q;
	logic [PORT_DATA_BITS-1:0] g_value_q;
	logic                      bad_opcode_q;

	logic [WORD_BITS-1:0]              pc_inc;
	logic [WORD_BITS-1:0]              rx_val;
	logic [WORD_BITS-1:0]              ry_val;
	logic [WORD_BITS-1:0]              alu;
	logic [ADDR_BITS+PORT_ADDR_BITS-1:0] load_addr_ext;
	logic [ADDR_BITS+PORT_ADDR_BITS-1:0] store_addr_ext;
	logic [ADDR_BITS-1:0]              rd_addr;
	logic                              rd_en;
	logic [ADDR_BITS-1:0]              wr_addr;
	logic [WORD_BITS-1:0]              wr_data;
	logic                              wr_en;
	logic                              res_wr;
	logic [WORD_BITS-1:0]              res_val;
	logic                              res_mw;
	logic                              res_bad;
	logic                              res_g;

	assign sts.op = op_q;
	assign pc_inc = pc_q + WORD_BITS'(1);

	// operand values; register 7 reads the already advanced pc
	assign rx_val = (rx_q == REG_PC) ? pc_q : (rf_vld_q[rx_q] ? rx_raw_q : '0);
	assign ry_val = (ry_q == REG_PC) ? pc_q : (rf_vld_q[ry_q] ? ry_raw_q : '0);
	assign alu    = (op_q == OP_SUB) ? (rx_val - ry_val) : (rx_val + ry_val);

	// address width conversions, depth is a power of two so addresses wrap by masking
	assign load_addr_ext  = {{ADDR_BITS{1'b0}}, load_addr};
	assign store_addr_ext = {{PORT_ADDR_BITS{1'b0}}, ry_val[ADDR_BITS-1:0]};

	// memory read port: fetch at pc, immediate at advanced pc, load at ry
	always_comb begin
		rd_en = cmd.fetch || cmd.decode || cmd.ld_read;
		priority if (cmd.fetch) begin
			rd_addr = pc_q[ADDR_BITS-1:0];
		end else if (cmd.decode) begin
			rd_addr = pc_inc[ADDR_BITS-1:0];
		end else begin
			rd_addr = ry_val[ADDR_BITS-1:0];
		end
	end

	// memory write port: load item or store instruction
	always_comb begin
		wr_en = cmd.load_wr || (cmd.finish_instr && res_mw);
		if (cmd.load_wr) begin
			wr_addr = load_addr_ext[ADDR_BITS-1:0];
			wr_data = WORD_BITS'(load_data);
		end else begin
			wr_addr = ry_val[ADDR_BITS-1:0];
			wr_data = rx_val;
		end
	end

	// word memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// execute result of the current instruction
	always_comb begin
		res_wr  = 1'b0;
		res_val = '0;
		res_mw  = 1'b0;
		res_bad = 1'b0;
		res_g   = 1'b0;
		unique case (op_q)
			OP_MV: begin
				res_wr  = 1'b1;
				res_val = ry_val;
			end
			OP_MVI: begin
				res_wr  = 1'b1;
				res_val = rd_q;
			end
			OP_ADD, OP_SUB: begin
				res_wr  = 1'b1;
				res_val = alu;
				res_g   = 1'b1;
			end
			OP_LD: begin
				res_wr  = 1'b1;
				res_val = rd_q;
			end
			OP_ST: begin
				res_mw = 1'b1;
			end
			OP_MVNZ: begin
				if (g_q != '0) begin
					res_wr  = 1'b1;
					res_val = ry_val;
				end
			end
			OP_BAD: begin
				res_bad = 1'b1;
			end
		endcase
	end

	// decode latch and operand reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q     <= OP_MV;
			rx_q     <= '0;
			ry_q     <= '0;
			rx_raw_q <= '0;
			ry_raw_q <= '0;
		end else if (cmd.decode) begin
			op_q     <= rd_q[15:13];
			rx_q     <= rd_q[12:10];
			ry_q     <= rd_q[9:7];
			rx_raw_q <= rf_mem[rd_q[12:10]];
			ry_raw_q <= rf_mem[rd_q[9:7]];
		end
	end

	// register file storage, entry valid bits kept apart
	always_ff @(posedge clk) begin
		if (cmd.finish_instr && res_wr && (rx_q != REG_PC)) begin
			rf_mem[rx_q] <= res_val;
		end
	end

	// pc, g and register valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			g_q      <= '0;
			rf_vld_q <= '0;
		end else begin
			if (cmd.decode) begin
				pc_q <= pc_inc + WORD_BITS'(rd_q[15:13] == OP_MVI);
			end
			if (cmd.finish_instr) begin
				if (res_wr && (rx_q == REG_PC)) begin
					pc_q <= res_val;
				end else if (res_wr) begin
					rf_vld_q[rx_q] <= 1'b1;
				end
				if (res_g) begin
					g_q <= alu;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish_load) begin
			pc_after_q    <= pc_q[PORT_DATA_BITS-1:0];
			reg_written_q <= 1'b0;
			reg_index_q   <= '0;
			reg_value_q   <= '0;
			mem_written_q <= 1'b0;
			store_addr_q  <= '0;
			store_data_q  <= '0;
			g_value_q     <= g_q[PORT_DATA_BITS-1:0];
			bad_opcode_q  <= 1'b0;
		end else if (cmd.finish_instr) begin
			pc_after_q    <= (res_wr && (rx_q == REG_PC)) ?
				res_val[PORT_DATA_BITS-1:0] : pc_q[PORT_DATA_BITS-1:0];
			reg_written_q <= res_wr;
			reg_index_q   <= res_wr ? rx_q : '0;
			reg_value_q   <= res_val[PORT_DATA_BITS-1:0];
			mem_written_q <= res_mw;
			store_addr_q  <= res_mw ? store_addr_ext[PORT_ADDR_BITS-1:0] : '0;
			store_data_q  <= res_mw ? rx_val[PORT_DATA_BITS-1:0] : '0;
			g_value_q     <= res_g ? alu[PORT_DATA_BITS-1:0] : g_q[PORT_DATA_BITS-1:0];
			bad_opcode_q  <= res_bad;
		end
	end

	assign pc_after    = pc_after_q;
	assign reg_written = reg_written_q;
	assign reg_index   = reg_index_q;
	assign reg_value   = reg_value_q;
	assign mem_written = mem_written_q;
	assign store_addr  = store_addr_q;
	assign store_data  = store_data_q;
	assign g_value     = g_value_q;
	assign bad_opcode  = bad_opcode_q;

endmodule

[design/simple_processor_execute.sv]
// top level of the simple processor execute block
// joins spe_ctrl and spe_datapath; depends on spe_pkg
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   in      | in_valid / in_stall  | req_type, load_addr, load_data
//   out     | out_valid / out_stall| pc_after, reg_written, reg_index, reg_value,
//           |                      | mem_written, store_addr, store_data,
//           |                      | g_value, bad_opcode
//
// a load item writes its word, then hands off; an instruction runs fetch, decode and
// execute, an ld also reads memory; the word memory's one read port serves all reads.
// one item is in work at a time; a finished result waits in the output register
// while the next item is accepted.
// reset clears pc, g and the register valid bits; the word memory is not cleared.
// a stalled output holds the finishing item in its last state until the register frees.
`timescale 1ns / 1ps

module simple_processor_execute import spe_pkg::*; #(
	parameter int WORD_BITS = SPE_WORD_BITS,
	parameter int MEM_WORDS = SPE_MEM_WORDS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      req_type,
	input  logic [PORT_ADDR_BITS-1:0] load_addr,
	input  logic [PORT_DATA_BITS-1:0] load_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [PORT_DATA_BITS-1:0] pc_after,
	output logic                      reg_written,
	output logic [REG_IDX_BITS-1:0]   reg_index,
	output logic [PORT_DATA_BITS-1:0] reg_value,
	output logic                      mem_written,
	output logic [PORT_ADDR_BITS-1:0] store_addr,
	output logic [PORT_DATA_BITS-1:0] store_data,
	output logic [PORT_DATA_BITS-1:0] g_value,
	output logic                      bad_opcode
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// sequencing
	spe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage and execution
	spe_datapath #(
		.WORD_BITS (WORD_BITS),
		.MEM_WORDS (MEM_WORDS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.load_addr   (load_addr),
		.load_data   (load_data),
		.pc_after    (pc_after),
		.reg_written (reg_written),
		.reg_index   (reg_index),
		.reg_value   (reg_value),
		.mem_written (mem_written),
		.store_addr  (store_addr),
		.store_data  (store_data),
		.g_value     (g_value),
		.bad_opcode  (bad_opcode)
	);

endmodule
